// ===== design/ned_pkg.sv =====
// Shared types, codes and constants of the normalized edit distance unit.
package ned_pkg;

    localparam int NED_MAX_LEN = 32;

    localparam int OP_W = 2;
    localparam int CH_W = 8;
    localparam int DIST_W = 6;
    localparam int LEN_W = 6;
    localparam int RATIO_W = 17;
    localparam int FRAC_W = 16;

    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [CH_W-1:0] ch;
    } ned_cmd_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [LEN_W-1:0]   longer_len;
        logic [RATIO_W-1:0] ratio;
        logic               both_empty;
        logic               overflowed;
    } ned_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_CELL_RD,
        ST_CELL_WR,
        ST_FINAL_RD,
        ST_FINAL,
        ST_DIV,
        ST_WAIT_OUT
    } ned_state_t;

endpackage

// ===== design/ned_if.sv =====
// Valid/ready channel interfaces for the command and result transfers.
interface ned_cmd_if import ned_pkg::*; ();
    logic     valid;
    logic     ready;
    ned_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ned_result_if import ned_pkg::*; ();
    logic        valid;
    logic        ready;
    ned_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/normalized_edit_distance_unit.sv =====
// String A and B loads can transfer back to back while the unit is idle.
// A compute fills the table cell by cell in the single row memory, each cell in a
// read state and a write state, and then runs the bit-serial divider.
// With both strings empty a compute skips table and divider. No new command is taken
// until the compute has handed its result to the output register.
// Reset clears the lengths, the overflow flag and the sequencer; string and row
// memories hold no reset value and are only read where written.
module normalized_edit_distance_unit import ned_pkg::*; #(
    parameter int MAX_LEN = NED_MAX_LEN
) (
    input logic         clk,
    input logic         rst_n,
    ned_cmd_if.sink     cmd,
    ned_result_if.source result
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SW = CW + 1;

    logic [CH_W-1:0] text_a_mem [MAX_LEN];
    logic [CH_W-1:0] text_b_mem [MAX_LEN];
    logic [CW-1:0]   dp_mem [MAX_LEN+1];

    ned_state_t  state_reg;
    ned_state_t  state_next;
    logic [CW-1:0] count_a_reg;
    logic [CW-1:0] count_b_reg;
    logic          overflow_reg;
    logic [CW-1:0] la_reg;
    logic [CW-1:0] lb_reg;
    logic [CW-1:0] longer_reg;
    logic          ovf_res_reg;
    logic          empty_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [SW-1:0] diag_reg;
    logic [SW-1:0] left_reg;
    logic [CW-1:0] dist_reg;
    logic [CH_W-1:0] ta_rd_reg;
    logic [CH_W-1:0] tb_rd_reg;
    logic [CW-1:0] dp_rd_reg;
    logic          out_valid_reg;
    ned_result_t   out_data_reg;

    logic          accept;
    logic          ta_we;
    logic          tb_we;
    logic          dp_we;
    logic [CW-1:0] dp_waddr;
    logic [CW-1:0] dp_wdata;
    logic [CW-1:0] dp_raddr;
    logic [CW-1:0] i_minus;
    logic [CW-1:0] j_minus;
    logic [SW-1:0] up_inc;
    logic [SW-1:0] left_inc;
    logic [SW-1:0] diag_cost;
    logic [SW-1:0] best;
    logic          div_start;
    logic          div_done;
    logic [RATIO_W-1:0] quotient;
    logic          out_load;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept = cmd.valid && cmd.ready;
    assign ta_we = accept && (cmd.data.op == OP_LOAD_A) && (count_a_reg < CW'(MAX_LEN));
    assign tb_we = accept && (cmd.data.op == OP_LOAD_B) && (count_b_reg < CW'(MAX_LEN));

    assign i_minus = i_reg - CW'(1);
    assign j_minus = j_reg - CW'(1);

    always_ff @(posedge clk)
    begin
        if (ta_we)
        begin
            text_a_mem[count_a_reg[AW-1:0]] <= cmd.data.ch;
        end
        ta_rd_reg <= text_a_mem[i_minus[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (tb_we)
        begin
            text_b_mem[count_b_reg[AW-1:0]] <= cmd.data.ch;
        end
        tb_rd_reg <= text_b_mem[j_minus[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (dp_we)
        begin
            dp_mem[dp_waddr] <= dp_wdata;
        end
        dp_rd_reg <= dp_mem[dp_raddr];
    end

    assign up_inc = {1'b0, dp_rd_reg} + SW'(1);
    assign left_inc = left_reg + SW'(1);
    assign diag_cost = diag_reg + ((ta_rd_reg != tb_rd_reg) ? SW'(1) : SW'(0));

    always_comb
    begin
        best = up_inc;
        if (best > left_inc)
        begin
            best = left_inc;
        end
        if (best > diag_cost)
        begin
            best = diag_cost;
        end
    end

    ned_divider #(
        .DIVISOR_W(CW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({dp_rd_reg, {FRAC_W{1'b0}}}),
        .divisor  (longer_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        dp_we = 1'b0;
        dp_waddr = j_reg;
        dp_wdata = j_reg;
        dp_raddr = j_reg;
        div_start = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.data.op == OP_COMPUTE))
                begin
                    if ((count_a_reg == '0) && (count_b_reg == '0))
                    begin
                        state_next = ST_WAIT_OUT;
                    end
                    else
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                dp_we = 1'b1;
                if (j_reg == lb_reg)
                begin
                    state_next = (la_reg == '0) ? ST_FINAL_RD : ST_ROW;
                end
            end
            ST_ROW:
            begin
                dp_we = 1'b1;
                dp_waddr = '0;
                dp_wdata = i_reg;
                if (lb_reg != '0)
                begin
                    state_next = ST_CELL_RD;
                end
                else if (i_reg == la_reg)
                begin
                    state_next = ST_FINAL_RD;
                end
            end
            ST_CELL_RD:
            begin
                state_next = ST_CELL_WR;
            end
            ST_CELL_WR:
            begin
                dp_we = 1'b1;
                dp_wdata = best[CW-1:0];
                if (j_reg == lb_reg)
                begin
                    state_next = (i_reg == la_reg) ? ST_FINAL_RD : ST_ROW;
                end
                else
                begin
                    state_next = ST_CELL_RD;
                end
            end
            ST_FINAL_RD:
            begin
                dp_raddr = lb_reg;
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_WAIT_OUT;
                end
            end
            ST_WAIT_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg <= '0;
            count_b_reg <= '0;
            overflow_reg <= 1'b0;
        end
        else if (accept)
        begin
            unique case (cmd.data.op)
                OP_LOAD_A:
                begin
                    if (ta_we)
                    begin
                        count_a_reg <= count_a_reg + CW'(1);
                    end
                    else
                    begin
                        overflow_reg <= 1'b1;
                    end
                end
                OP_LOAD_B:
                begin
                    if (tb_we)
                    begin
                        count_b_reg <= count_b_reg + CW'(1);
                    end
                    else
                    begin
                        overflow_reg <= 1'b1;
                    end
                end
                OP_COMPUTE:
                begin
                    count_a_reg <= '0;
                    count_b_reg <= '0;
                    overflow_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (cmd.data.op == OP_COMPUTE))
        begin
            la_reg <= count_a_reg;
            lb_reg <= count_b_reg;
            longer_reg <= (count_a_reg > count_b_reg) ? count_a_reg : count_b_reg;
            ovf_res_reg <= overflow_reg;
            empty_reg <= (count_a_reg == '0) && (count_b_reg == '0);
            dist_reg <= '0;
            i_reg <= CW'(1);
            j_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_INIT:
                begin
                    if (j_reg != lb_reg)
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                end
                ST_ROW:
                begin
                    diag_reg <= SW'(i_minus);
                    left_reg <= SW'(i_reg);
                    j_reg <= CW'(1);
                    if ((lb_reg == '0) && (i_reg != la_reg))
                    begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
                ST_CELL_WR:
                begin
                    left_reg <= best;
                    diag_reg <= {1'b0, dp_rd_reg};
                    if (j_reg == lb_reg)
                    begin
                        if (i_reg != la_reg)
                        begin
                            i_reg <= i_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                end
                ST_FINAL:
                begin
                    dist_reg <= dp_rd_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.distance <= DIST_W'(dist_reg);
            out_data_reg.longer_len <= LEN_W'(longer_reg);
            out_data_reg.ratio <= empty_reg ? '0 : quotient;
            out_data_reg.both_empty <= empty_reg;
            out_data_reg.overflowed <= ovf_res_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data = out_data_reg;

endmodule

// ===== design/ned_divider.sv =====
// Restoring serial divider that produces one quotient bit per cycle.
module ned_divider import ned_pkg::*; #(
    parameter int DIVISOR_W = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [DIVISOR_W+FRAC_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]        divisor,
    output logic                        done,
    output logic [RATIO_W-1:0]          quotient
);

    localparam int QW = DIVISOR_W + FRAC_W;
    localparam int CNTW = $clog2(QW + 1);

    logic [QW-1:0]        quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] div_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[QW-1]};
    assign diff = trial - {1'b0, div_reg};
    assign fits = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNTW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[QW-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg[RATIO_W-1:0];

endmodule

// ===== verif/tb_normalized_edit_distance_unit.sv =====
// Testbench for the normalized edit distance unit with directed and random string loads.
`timescale 1ns / 100ps

module tb_normalized_edit_distance_unit;
    import ned_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CLK_PERIOD = 12;
    localparam int ITEM_TARGET = 900;
    localparam int DRAIN_CYCLES = 2500;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_STEADY,
        SINK_RANDOM,
        SINK_SPARSE
    } sink_mode_t;

    logic clk;
    logic rst_n;
    longint cycle_count;
    int error_count;

    ned_cmd_if cmd_ch ();
    ned_result_if res_ch ();

    normalized_edit_distance_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    ned_cmd_t pending_cmds[$];
    ned_result_t expected_scores[$];
    int total_cmds;
    int accepted_cmds;

    logic [CH_W-1:0] shadow_a[NED_MAX_LEN];
    logic [CH_W-1:0] shadow_b[NED_MAX_LEN];
    int shadow_len_a;
    int shadow_len_b;
    logic shadow_overflow;

    int burst_left;
    int gap_left;

    sink_mode_t sink_mode;
    int sink_mode_left;
    int sink_tick;
    ned_result_t wanted;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_normalized_edit_distance_unit: errors");
            $finish;
        end
    end

    function automatic int edit_distance();
        int row[NED_MAX_LEN + 1];
        int diag;
        int above;
        int best;
        int cost;
        for (int j = 0; j <= shadow_len_b; j++)
        begin
            row[j] = j;
        end
        for (int i = 1; i <= shadow_len_a; i++)
        begin
            diag = row[0];
            row[0] = i;
            for (int j = 1; j <= shadow_len_b; j++)
            begin
                above = row[j];
                cost = (shadow_a[i - 1] == shadow_b[j - 1]) ? 0 : 1;
                best = above + 1;
                if (row[j - 1] + 1 < best)
                begin
                    best = row[j - 1] + 1;
                end
                if (diag + cost < best)
                begin
                    best = diag + cost;
                end
                diag = above;
                row[j] = best;
            end
        end
        return row[shadow_len_b];
    endfunction

    task automatic score_command(input ned_cmd_t c);
        ned_result_t r;
        int longer;
        int dist_val;
        case (c.op)
            OP_LOAD_A:
            begin
                if (shadow_len_a < NED_MAX_LEN)
                begin
                    shadow_a[shadow_len_a] = c.ch;
                    shadow_len_a++;
                end
                else
                begin
                    shadow_overflow = 1'b1;
                end
            end
            OP_LOAD_B:
            begin
                if (shadow_len_b < NED_MAX_LEN)
                begin
                    shadow_b[shadow_len_b] = c.ch;
                    shadow_len_b++;
                end
                else
                begin
                    shadow_overflow = 1'b1;
                end
            end
            OP_COMPUTE:
            begin
                longer = (shadow_len_a > shadow_len_b) ? shadow_len_a : shadow_len_b;
                r = '0;
                r.longer_len = longer[LEN_W-1:0];
                r.overflowed = shadow_overflow;
                if (longer == 0)
                begin
                    r.both_empty = 1'b1;
                end
                else
                begin
                    dist_val = edit_distance();
                    r.distance = dist_val[DIST_W-1:0];
                    r.ratio = RATIO_W'((dist_val << FRAC_W) / longer);
                end
                expected_scores.push_back(r);
                shadow_len_a = 0;
                shadow_len_b = 0;
                shadow_overflow = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch);
        ned_cmd_t c;
        c.op = op;
        c.ch = ch;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_job(input int na, input int nb);
        logic [CH_W-1:0] a_txt[$];
        logic [CH_W-1:0] b_txt[$];
        logic [CH_W-1:0] base;
        logic [CH_W-1:0] pick;
        int narrow;
        int related;
        int ia;
        int ib;
        narrow = $urandom_range(0, 1);
        related = $urandom_range(0, 1);
        base = CH_W'($urandom);
        for (int i = 0; i < na; i++)
        begin
            pick = narrow ? base + CH_W'($urandom_range(0, 3)) : CH_W'($urandom);
            a_txt.push_back(pick);
        end
        for (int j = 0; j < nb; j++)
        begin
            pick = narrow ? base + CH_W'($urandom_range(0, 3)) : CH_W'($urandom);
            if (related && j < na && $urandom_range(0, 3) != 0)
            begin
                pick = a_txt[j];
            end
            b_txt.push_back(pick);
        end
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                queue_cmd(OP_UNUSED, CH_W'($urandom));
            end
            if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1))
            begin
                queue_cmd(OP_LOAD_A, a_txt[ia]);
                ia++;
            end
            else
            begin
                queue_cmd(OP_LOAD_B, b_txt[ib]);
                ib++;
            end
        end
        queue_cmd(OP_COMPUTE, CH_W'($urandom));
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return $urandom_range(0, 6);
        end
        else if (r < 93)
        begin
            return $urandom_range(7, 16);
        end
        return $urandom_range(28, 36);
    endfunction

    // Sender: bursts of transfers separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                score_command(cmd_ch.data);
                accepted_cmds++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd_ch.data <= pending_cmds.pop_front();
                    cmd_ch.valid <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern that switches between several modes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            sink_mode = SINK_OPEN;
            sink_mode_left = 0;
            sink_tick = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_scores.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p", $time,
                             res_ch.data);
                    error_count++;
                end
                else
                begin
                    wanted = expected_scores.pop_front();
                    report_field("distance", wanted.distance, res_ch.data.distance);
                    report_field("longer_len", wanted.longer_len, res_ch.data.longer_len);
                    report_field("ratio", wanted.ratio, res_ch.data.ratio);
                    report_field("both_empty", wanted.both_empty, res_ch.data.both_empty);
                    report_field("overflowed", wanted.overflowed, res_ch.data.overflowed);
                end
            end
            if (sink_mode_left == 0)
            begin
                sink_mode = sink_mode_t'($urandom_range(0, 3));
                sink_mode_left = $urandom_range(32, 256);
            end
            else
            begin
                sink_mode_left--;
            end
            sink_tick++;
            case (sink_mode)
                SINK_OPEN: res_ch.ready <= 1'b1;
                SINK_STEADY: res_ch.ready <= (sink_tick % 4) != 0;
                SINK_RANDOM: res_ch.ready <= 1'($urandom_range(0, 1));
                default: res_ch.ready <= (sink_tick % 16) < 2;
            endcase
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cycle_count = 0;
        error_count = 0;
        accepted_cmds = 0;
        shadow_len_a = 0;
        shadow_len_b = 0;
        shadow_overflow = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        res_ch.ready = 1'b0;

        // Both strings empty, then one string empty.
        queue_cmd(OP_COMPUTE, 8'h00);
        queue_cmd(OP_LOAD_A, 8'h00);
        queue_cmd(OP_COMPUTE, 8'hFF);
        queue_cmd(OP_LOAD_B, 8'hFF);
        queue_cmd(OP_COMPUTE, 8'h5A);
        // Identical strings, swapped strings and the unused selector.
        queue_cmd(OP_LOAD_B, 8'hFF);
        queue_cmd(OP_LOAD_A, 8'hFF);
        queue_cmd(OP_COMPUTE, 8'h00);
        queue_cmd(OP_LOAD_A, 8'h00);
        queue_cmd(OP_LOAD_A, 8'hFF);
        queue_cmd(OP_UNUSED, 8'hA5);
        queue_cmd(OP_LOAD_B, 8'hFF);
        queue_cmd(OP_LOAD_B, 8'h00);
        queue_cmd(OP_UNUSED, 8'h5A);
        queue_cmd(OP_COMPUTE, 8'hFF);
        queue_cmd(OP_LOAD_A, 8'h80);
        queue_cmd(OP_LOAD_B, 8'h01);
        queue_cmd(OP_LOAD_B, 8'h80);
        queue_cmd(OP_COMPUTE, 8'h7F);
        queue_cmd(OP_UNUSED, 8'hFF);
        queue_cmd(OP_COMPUTE, 8'h00);

        // Full strings with dropped characters, and full strings exactly.
        queue_job(33, 34);
        queue_job(32, 32);
        while (pending_cmds.size() < ITEM_TARGET)
        begin
            queue_job(pick_len(), pick_len());
        end
        total_cmds = pending_cmds.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cmds < total_cmds)
        begin
            @(posedge clk);
        end
        while (expected_scores.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("tb_normalized_edit_distance_unit: clean");
        end
        else
        begin
            $display("tb_normalized_edit_distance_unit: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ned_pkg.sv
design/ned_if.sv
design/ned_divider.sv
design/normalized_edit_distance_unit.sv
verif/tb_normalized_edit_distance_unit.sv
